@@ rtl/ter_pkg.sv @@
// ----------------------------------------------------------------------------
// ter_pkg
// Shared constants, codes and control structs of the edge-function rasterizer.
// ----------------------------------------------------------------------------
package ter_pkg;

  localparam int unsigned SUBPIXEL_BITS = 4;
  localparam int unsigned MAX_WIDTH     = 256;
  localparam int unsigned MAX_HEIGHT    = 256;
  localparam int unsigned DEPTH_W       = 24;
  localparam int unsigned ZADDR_W       = 16;
  localparam int unsigned ACC_W         = 64;
  localparam int unsigned NUM_W         = 60;
  localparam int unsigned QUOT_W        = 24;
  localparam int unsigned STEP_W        = 5;
  localparam int unsigned MUL_A_W       = 19;
  localparam int unsigned MUL_B_W       = 25;
  localparam int unsigned HALF_W        = 18;

  localparam logic       OP_LOAD      = 1'b0;
  localparam logic       OP_ADVANCE   = 1'b1;
  localparam logic [1:0] SLOT_SETUP   = 2'd2;
  localparam logic [1:0] SLOT_INVALID = 2'd3;

  localparam logic [1:0] CFG_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_WINDING = 2'd2;
  localparam logic [1:0] CFG_CULL    = 2'd3;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_SETUP  = 2'd1,
    KIND_PIXEL  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_CULLED  = 3'd1,
    STAT_OUTSIDE = 3'd2,
    STAT_ZERO    = 3'd3,
    STAT_NO_TRI  = 3'd4
  } status_e;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
    logic shift;
  } mac_ctl_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

@@ rtl/ter_mac.sv @@
// ----------------------------------------------------------------------------
// ter_mac
// Shared signed multiply-accumulate unit: one 19x25 product per cycle.
// ----------------------------------------------------------------------------
module ter_mac (
  input  logic                                clk_i,
  input  ter_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [ter_pkg::MUL_A_W-1:0]  opa_i,
  input  logic signed [ter_pkg::MUL_B_W-1:0]  opb_i,
  output logic signed [ter_pkg::ACC_W-1:0]    acc_o
);
  import ter_pkg::*;

  localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  acc_q;

  assign prod = opa_i * opb_i;

  always_comb begin
    term = ACC_W'(prod);
    if (ctl_i.shift) begin
      term = term <<< HALF_W;
    end
    base  = ctl_i.clr ? '0 : acc_q;
    acc_d = ctl_i.sub ? base - term : base + term;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ rtl/ter_div.sv @@
// ----------------------------------------------------------------------------
// ter_div
// Restoring divider, one quotient bit per cycle, up to 24 bits.
// ----------------------------------------------------------------------------
module ter_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ter_pkg::div_ctl_t             ctl_i,
  input  logic [ter_pkg::NUM_W-1:0]     rem_i,
  input  logic [ter_pkg::QUOT_W-1:0]    low_i,
  input  logic [ter_pkg::NUM_W-1:0]     den_i,
  output logic [ter_pkg::QUOT_W-1:0]    quot_o,
  output logic                          done_o
);
  import ter_pkg::*;

  logic [NUM_W-1:0]  rem_q;
  logic [QUOT_W-1:0] low_q;
  logic [NUM_W-1:0]  den_q;
  logic [QUOT_W-1:0] quot_q;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [NUM_W:0]    trial;
  logic [NUM_W:0]    diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, low_q[QUOT_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !ctl_i.start && (cnt_q == STEP_W'(1));
      if (ctl_i.start) begin
        cnt_q <= ctl_i.steps;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q  <= rem_i;
      low_q  <= low_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
      low_q  <= {low_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

@@ rtl/ter_zmem.sv @@
// ----------------------------------------------------------------------------
// ter_zmem
// Depth store, one read and one write port, swept to farthest after reset.
// ----------------------------------------------------------------------------
module ter_zmem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [ter_pkg::ZADDR_W-1:0]   rd_addr_i,
  output logic [ter_pkg::DEPTH_W-1:0]   rd_data_o,
  input  logic                          wr_en_i,
  input  logic [ter_pkg::ZADDR_W-1:0]   wr_addr_i,
  input  logic [ter_pkg::DEPTH_W-1:0]   wr_data_i,
  output logic                          clearing_o
);
  import ter_pkg::*;

  localparam int unsigned DEPTH = 1 << ZADDR_W;

  logic [DEPTH_W-1:0] mem [DEPTH];
  logic [DEPTH_W-1:0] rd_q;
  logic               clr_q;
  logic [ZADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '1;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_q;
  assign clearing_o = clr_q;

endmodule

@@ rtl/triangle_edge_rasterizer.sv @@
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer
// Edge-function triangle rasterizer with depth test and perspective weights.
// Vertex beat, bad slot or advance without triangle: answered from idle.
// Set-up: S_AREA, S_SETUP, then S_BOX unless zero area or culled. Pixel: S_EDGE,
// S_COVER, then for a covered pixel S_ZMUL to S_VDIV on one shared multiplier (18
// products per covered pixel) and one bit-serial divider (up to 56 bits), then
// S_PIXOUT. One item at a time; busy is high meanwhile and the receiver cannot
// stall. Reset: a clearing pass sets the depth store to farthest.
// ----------------------------------------------------------------------------
module triangle_edge_rasterizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                operation_i,
  input  logic [1:0]          vertex_slot_i,
  input  logic signed [15:0]  vert_x_i,
  input  logic signed [15:0]  vert_y_i,
  input  logic [23:0]         vert_depth_i,
  input  logic [23:0]         vert_inv_w_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [8:0]          cfg_data_i,
  output logic                done_o,
  output logic [1:0]          kind_o,
  output logic [2:0]          status_o,
  output logic [7:0]          pix_x_o,
  output logic [7:0]          pix_y_o,
  output logic                covered_o,
  output logic                depth_written_o,
  output logic [23:0]         pix_depth_o,
  output logic [15:0]         bary_u_o,
  output logic [15:0]         bary_v_o,
  output logic                last_pixel_o
);
  import ter_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_AREA   = 14'b00000000000100,
    S_SETUP  = 14'b00000000001000,
    S_BOX    = 14'b00000000010000,
    S_EDGE   = 14'b00000000100000,
    S_COVER  = 14'b00000001000000,
    S_ZMUL   = 14'b00000010000000,
    S_ZDIV   = 14'b00000100000000,
    S_NMUL   = 14'b00001000000000,
    S_DSUM   = 14'b00010000000000,
    S_UDIV   = 14'b00100000000000,
    S_VDIV   = 14'b01000000000000,
    S_PIXOUT = 14'b10000000000000
  } state_e;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [7:0]         px;
    logic [7:0]         py;
    logic               cov;
    logic               wr;
    logic [DEPTH_W-1:0] depth;
    logic [15:0]        u;
    logic [15:0]        v;
    logic               last;
  } res_t;

  localparam int unsigned E_W = 37;

  function automatic res_t make_res(kind_e k, status_e s);
    res_t r;
    r        = '0;
    r.kind   = k;
    r.status = s;
    return r;
  endfunction

  function automatic logic [8:0] clamp_dim(logic [8:0] v, logic [8:0] maxv);
    logic [8:0] r;
    r = v;
    if (v == '0) r = 9'd1;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  function automatic logic tie_bit(logic signed [16:0] dx, logic signed [16:0] dy);
    return (dx != '0) ? !dx[16] : ((dy != '0) && !dy[16]);
  endfunction

  function automatic logic in_edge(logic signed [E_W-1:0] e, logic tie);
    return (e == '0) ? tie : !e[E_W-1];
  endfunction

  // configuration
  logic [8:0] vw_q, vh_q;
  logic       ccw_q, cull_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q   <= 9'(MAX_WIDTH);
      vh_q   <= 9'(MAX_HEIGHT);
      ccw_q  <= 1'b1;
      cull_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:   vw_q   <= clamp_dim(cfg_data_i, 9'(MAX_WIDTH));
        CFG_HEIGHT:  vh_q   <= clamp_dim(cfg_data_i, 9'(MAX_HEIGHT));
        CFG_WINDING: ccw_q  <= cfg_data_i[0];
        CFG_CULL:    cull_q <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  state_e              state_q;
  logic [2:0]          cnt_q;
  logic                active_q;
  logic [2:0]          tie_q;
  logic [7:0]          bx0_q, bx1_q, by0_q, by1_q;
  logic [7:0]          px_q, py_q;
  logic [33:0]         area_q;
  logic                done_q;
  logic                done_d;
  res_t                res_q;

  logic signed [15:0]  cx_q [3];
  logic signed [15:0]  cy_q [3];
  logic [DEPTH_W-1:0]  cz_q [3];
  logic [23:0]         cw_q [3];
  logic signed [E_W-1:0] e_q [3];
  logic [NUM_W-1:0]    n_q [3];
  logic [NUM_W-1:0]    d_q;
  logic [DEPTH_W-1:0]  z_q;
  logic [15:0]         u_q, v_q;
  logic                cov_q;
  logic [ZADDR_W-1:0]  addr_q;

  mac_ctl_t                  mac_ctl;
  logic signed [MUL_A_W-1:0] opa;
  logic signed [MUL_B_W-1:0] opb;
  logic signed [ACC_W-1:0]   acc;
  div_ctl_t                  div_ctl;
  logic [NUM_W-1:0]          div_rem, div_den;
  logic [QUOT_W-1:0]         div_low, quot;
  logic                      div_done;
  logic [DEPTH_W-1:0]        rd_data;
  logic                      clearing;
  logic                      rd_en, wr_en;
  logic [16:0]               addr_full;

  assign busy = (state_q != S_IDLE);

  // doubled corner coordinates and sample centre
  logic signed [17:0] xd [3];
  logic signed [17:0] yd [3];
  logic signed [17:0] sxs, sys;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xd[i] = {cx_q[i][15], cx_q[i], 1'b0};
      yd[i] = {cy_q[i][15], cy_q[i], 1'b0};
    end
    sxs = 18'({px_q, 1'b1, {SUBPIXEL_BITS{1'b0}}});
    sys = 18'({py_q, 1'b1, {SUBPIXEL_BITS{1'b0}}});
  end

  // area differences at raster resolution
  logic signed [16:0] dx10, dy10, dx20, dy20, dx21, dy21, dx02, dy02;
  assign dx10 = {cx_q[1][15], cx_q[1]} - {cx_q[0][15], cx_q[0]};
  assign dy10 = {cy_q[1][15], cy_q[1]} - {cy_q[0][15], cy_q[0]};
  assign dx20 = {cx_q[2][15], cx_q[2]} - {cx_q[0][15], cx_q[0]};
  assign dy20 = {cy_q[2][15], cy_q[2]} - {cy_q[0][15], cy_q[0]};
  assign dx21 = {cx_q[2][15], cx_q[2]} - {cx_q[1][15], cx_q[1]};
  assign dy21 = {cy_q[2][15], cy_q[2]} - {cy_q[1][15], cy_q[1]};
  assign dx02 = {cx_q[0][15], cx_q[0]} - {cx_q[2][15], cx_q[2]};
  assign dy02 = {cy_q[0][15], cy_q[0]} - {cy_q[2][15], cy_q[2]};

  // bounding box of the corners
  logic signed [15:0] xmin, xmax, ymin, ymax;
  logic               outside;
  logic [7:0]         bx0, bx1, by0, by1;
  always_comb begin
    xmin = cx_q[0]; xmax = cx_q[0];
    ymin = cy_q[0]; ymax = cy_q[0];
    for (int i = 1; i < 3; i++) begin
      if (cx_q[i] < xmin) xmin = cx_q[i];
      if (cx_q[i] > xmax) xmax = cx_q[i];
      if (cy_q[i] < ymin) ymin = cy_q[i];
      if (cy_q[i] > ymax) ymax = cy_q[i];
    end
    outside = (18'(xmin) + 18'sd16 > $signed(18'({vw_q, {SUBPIXEL_BITS{1'b0}}})))
           || xmax[15]
           || (18'(ymin) + 18'sd16 > $signed(18'({vh_q, {SUBPIXEL_BITS{1'b0}}})))
           || ymax[15];
    bx0 = xmin[15] ? 8'd0 : xmin[SUBPIXEL_BITS+7:SUBPIXEL_BITS];
    by0 = ymin[15] ? 8'd0 : ymin[SUBPIXEL_BITS+7:SUBPIXEL_BITS];
    bx1 = (12'(xmax[15:SUBPIXEL_BITS]) > 12'(vw_q - 9'd1)) ? 8'(vw_q - 9'd1)
                                                          : xmax[SUBPIXEL_BITS+7:SUBPIXEL_BITS];
    by1 = (12'(ymax[15:SUBPIXEL_BITS]) > 12'(vh_q - 9'd1)) ? 8'(vh_q - 9'd1)
                                                          : ymax[SUBPIXEL_BITS+7:SUBPIXEL_BITS];
  end

  // edge operands for the edge picked by the step counter
  logic signed [17:0] xa, ya, xb, yb;
  logic [35:0]        uu;
  logic [DEPTH_W-1:0] zz;
  logic [23:0]        ww;
  logic [HALF_W-1:0]  uhalf;
  always_comb begin
    case (cnt_q[2:1])
      2'd0: begin
        xa = xd[1]; ya = yd[1]; xb = xd[2]; yb = yd[2];
        uu = e_q[0][35:0]; zz = cz_q[0]; ww = cw_q[0];
      end
      2'd1: begin
        xa = xd[2]; ya = yd[2]; xb = xd[0]; yb = yd[0];
        uu = e_q[1][35:0]; zz = cz_q[1]; ww = cw_q[1];
      end
      default: begin
        xa = xd[0]; ya = yd[0]; xb = xd[1]; yb = yd[1];
        uu = e_q[2][35:0]; zz = cz_q[2]; ww = cw_q[2];
      end
    endcase
    uhalf = cnt_q[0] ? uu[35:HALF_W] : uu[HALF_W-1:0];
  end

  // operand and control selection for the shared multiplier
  logic signed [17:0] t0, t1;
  always_comb begin
    mac_ctl = '0;
    opa     = '0;
    opb     = '0;
    t0      = '0;
    t1      = '0;
    case (state_q)
      S_AREA: begin
        mac_ctl.en = 1'b1;
        if (cnt_q[0] == 1'b0) begin
          mac_ctl.clr = 1'b1;
          mac_ctl.sub = !ccw_q;
          opa = MUL_A_W'(dx20);
          opb = MUL_B_W'(dy10);
        end else begin
          mac_ctl.sub = ccw_q;
          opa = MUL_A_W'(dy20);
          opb = MUL_B_W'(dx10);
        end
      end
      S_EDGE: begin
        mac_ctl.en = (cnt_q != 3'd6);
        if (cnt_q[0] == 1'b0) begin
          mac_ctl.clr = 1'b1;
          mac_ctl.sub = !ccw_q;
          t0 = sxs - xa;
          t1 = yb - ya;
        end else begin
          mac_ctl.sub = ccw_q;
          t0 = sys - ya;
          t1 = xb - xa;
        end
        opa = MUL_A_W'(t0);
        opb = MUL_B_W'(t1);
      end
      S_ZMUL: begin
        mac_ctl.en    = (cnt_q != 3'd6);
        mac_ctl.clr   = (cnt_q == 3'd0);
        mac_ctl.shift = cnt_q[0];
        opa = $signed({1'b0, uhalf});
        opb = $signed({1'b0, zz});
      end
      S_NMUL: begin
        mac_ctl.en    = (cnt_q != 3'd6);
        mac_ctl.clr   = !cnt_q[0];
        mac_ctl.shift = cnt_q[0];
        opa = $signed({1'b0, uhalf});
        opb = $signed({1'b0, ww});
      end
      default: ;
    endcase
  end

  ter_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .opa_i (opa),
    .opb_i (opb),
    .acc_o (acc)
  );

  // divider launches: depth quotient and the two weight fractions
  logic n0_ge, n1_ge;
  assign n0_ge = n_q[0] >= d_q;
  assign n1_ge = n_q[1] >= d_q;

  always_comb begin
    div_ctl = '0;
    div_rem = '0;
    div_low = '0;
    div_den = d_q;
    case (state_q)
      S_ZMUL: begin
        div_ctl.start = (cnt_q == 3'd6);
        div_ctl.steps = STEP_W'(QUOT_W);
        div_rem = NUM_W'(acc[NUM_W-1:QUOT_W]);
        div_low = acc[QUOT_W-1:0];
        div_den = NUM_W'({area_q, 2'b00});
      end
      S_UDIV: begin
        div_ctl.start = !cnt_q[0] && (d_q != '0) && !n0_ge;
        div_ctl.steps = STEP_W'(16);
        div_rem = n_q[0];
      end
      S_VDIV: begin
        div_ctl.start = !cnt_q[0] && (d_q != '0) && !n1_ge;
        div_ctl.steps = STEP_W'(16);
        div_rem = n_q[1];
      end
      default: ;
    endcase
  end

  ter_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .rem_i  (div_rem),
    .low_i  (div_low),
    .den_i  (div_den),
    .quot_o (quot),
    .done_o (div_done)
  );

  // coverage and depth store access
  logic cov;
  logic last;
  assign cov = in_edge(e_q[0], tie_q[0]) && in_edge(e_q[1], tie_q[1])
            && in_edge(e_q[2], tie_q[2]);
  assign addr_full = 17'(py_q * vw_q) + 17'(px_q);
  assign rd_en = (state_q == S_COVER) && cov;
  assign wr_en = (state_q == S_PIXOUT) && cov_q && (z_q < rd_data);
  assign last  = (px_q >= bx1_q) && (py_q >= by1_q);

  ter_zmem u_zmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (addr_full[ZADDR_W-1:0]),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (addr_q),
    .wr_data_i  (z_q),
    .clearing_o (clearing)
  );

  logic load_en, swap_en;
  assign load_en = (state_q == S_IDLE) && start && (operation_i == OP_LOAD)
                && (vertex_slot_i != SLOT_INVALID);
  assign swap_en = (state_q == S_SETUP) && (acc != '0) && acc[ACC_W-1] && !cull_q;

  logic signed [ACC_W-1:0] mag;
  assign mag = acc[ACC_W-1] ? -acc : acc;

  // result strobe for the beat that completes at this edge
  always_comb begin
    done_d = 1'b0;
    case (state_q)
      S_IDLE:  done_d = start && ((operation_i == OP_LOAD) ? (vertex_slot_i != SLOT_SETUP)
                                                           : !active_q);
      S_SETUP: done_d = (acc == '0) || (acc[ACC_W-1] && cull_q);
      S_BOX:   done_d = 1'b1;
      S_PIXOUT: done_d = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      case (vertex_slot_i)
        2'd0: begin
          cx_q[0] <= vert_x_i; cy_q[0] <= vert_y_i;
          cz_q[0] <= vert_depth_i; cw_q[0] <= vert_inv_w_i;
        end
        2'd1: begin
          cx_q[1] <= vert_x_i; cy_q[1] <= vert_y_i;
          cz_q[1] <= vert_depth_i; cw_q[1] <= vert_inv_w_i;
        end
        default: begin
          cx_q[2] <= vert_x_i; cy_q[2] <= vert_y_i;
          cz_q[2] <= vert_depth_i; cw_q[2] <= vert_inv_w_i;
        end
      endcase
    end
    if (swap_en) begin
      cx_q[1] <= cx_q[2]; cx_q[2] <= cx_q[1];
      cy_q[1] <= cy_q[2]; cy_q[2] <= cy_q[1];
      cz_q[1] <= cz_q[2]; cz_q[2] <= cz_q[1];
      cw_q[1] <= cw_q[2]; cw_q[2] <= cw_q[1];
    end
    if ((state_q == S_EDGE) || (state_q == S_NMUL)) begin
      case (cnt_q)
        3'd2: begin
          e_q[0] <= (state_q == S_EDGE) ? acc[E_W-1:0] : e_q[0];
          n_q[0] <= acc[NUM_W-1:0];
        end
        3'd4: begin
          e_q[1] <= (state_q == S_EDGE) ? acc[E_W-1:0] : e_q[1];
          n_q[1] <= acc[NUM_W-1:0];
        end
        3'd6: begin
          e_q[2] <= (state_q == S_EDGE) ? acc[E_W-1:0] : e_q[2];
          n_q[2] <= acc[NUM_W-1:0];
        end
        default: ;
      endcase
    end
    if (state_q == S_COVER) begin
      cov_q  <= cov;
      addr_q <= addr_full[ZADDR_W-1:0];
    end
    if ((state_q == S_ZDIV) && div_done) begin
      z_q <= quot;
    end
    if (state_q == S_DSUM) begin
      d_q <= n_q[0] + n_q[1] + n_q[2];
    end
    if ((state_q == S_UDIV) && !cnt_q[0]) begin
      u_q <= (d_q == '0) ? 16'd0 : 16'hFFFF;
    end else if ((state_q == S_UDIV) && div_done) begin
      u_q <= quot[15:0];
    end
    if ((state_q == S_VDIV) && !cnt_q[0]) begin
      v_q <= (d_q == '0) ? 16'd0 : 16'hFFFF;
    end else if ((state_q == S_VDIV) && div_done) begin
      v_q <= quot[15:0];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      active_q <= 1'b0;
      tie_q    <= '0;
      bx0_q    <= '0;
      bx1_q    <= '0;
      by0_q    <= '0;
      by1_q    <= '0;
      px_q     <= '0;
      py_q     <= '0;
      area_q   <= '0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      done_q <= done_d;
      case (state_q)
        S_CLEAR: begin
          if (!clearing) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            if (operation_i == OP_LOAD) begin
              active_q <= 1'b0;
              if (vertex_slot_i == SLOT_INVALID) begin
                res_q <= make_res(KIND_VERTEX, STAT_NO_TRI);
              end else if (vertex_slot_i == SLOT_SETUP) begin
                state_q <= S_AREA;
                cnt_q   <= '0;
              end else begin
                res_q <= make_res(KIND_VERTEX, STAT_OK);
              end
            end else if (!active_q) begin
              res_q <= make_res(KIND_PIXEL, STAT_NO_TRI);
            end else begin
              state_q <= S_EDGE;
              cnt_q   <= '0;
            end
          end
        end
        S_AREA: begin
          if (cnt_q[0]) begin
            state_q <= S_SETUP;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SETUP: begin
          if (acc == '0) begin
            res_q   <= make_res(KIND_SETUP, STAT_ZERO);
            state_q <= S_IDLE;
          end else if (acc[ACC_W-1] && cull_q) begin
            res_q   <= make_res(KIND_SETUP, STAT_CULLED);
            state_q <= S_IDLE;
          end else begin
            res_q   <= make_res(KIND_SETUP, STAT_OK);
            area_q  <= mag[33:0];
            state_q <= S_BOX;
          end
        end
        S_BOX: begin
          state_q <= S_IDLE;
          if (outside) begin
            res_q.status <= STAT_OUTSIDE;
          end else begin
            res_q.status <= STAT_OK;
            res_q.px     <= bx0;
            res_q.py     <= by0;
            bx0_q    <= bx0;
            bx1_q    <= bx1;
            by0_q    <= by0;
            by1_q    <= by1;
            px_q     <= bx0;
            py_q     <= by0;
            tie_q    <= {tie_bit(dx10, dy10), tie_bit(dx02, dy02), tie_bit(dx21, dy21)};
            active_q <= 1'b1;
          end
        end
        S_EDGE: begin
          if (cnt_q == 3'd6) begin
            state_q <= S_COVER;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_COVER: begin
          state_q <= cov ? S_ZMUL : S_PIXOUT;
        end
        S_ZMUL: begin
          if (cnt_q == 3'd6) begin
            state_q <= S_ZDIV;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_ZDIV: begin
          if (div_done) state_q <= S_NMUL;
        end
        S_NMUL: begin
          if (cnt_q == 3'd6) begin
            state_q <= S_DSUM;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DSUM: begin
          state_q <= S_UDIV;
        end
        S_UDIV: begin
          if (!cnt_q[0]) begin
            if ((d_q == '0) || n0_ge) state_q <= S_VDIV;
            else cnt_q <= 3'd1;
          end else if (div_done) begin
            state_q <= S_VDIV;
            cnt_q   <= '0;
          end
        end
        S_VDIV: begin
          if (!cnt_q[0]) begin
            if ((d_q == '0) || n1_ge) state_q <= S_PIXOUT;
            else cnt_q <= 3'd1;
          end else if (div_done) begin
            state_q <= S_PIXOUT;
            cnt_q   <= '0;
          end
        end
        S_PIXOUT: begin
          state_q      <= S_IDLE;
          res_q.kind   <= KIND_PIXEL;
          res_q.status <= STAT_OK;
          res_q.px     <= px_q;
          res_q.py     <= py_q;
          res_q.cov    <= cov_q;
          res_q.wr     <= wr_en;
          res_q.depth  <= cov_q ? z_q : '0;
          res_q.u      <= cov_q ? u_q : '0;
          res_q.v      <= cov_q ? v_q : '0;
          res_q.last   <= last;
          // advance the scan in row-major order
          if (px_q >= bx1_q) begin
            px_q <= bx0_q;
            if (py_q >= by1_q) active_q <= 1'b0;
            else py_q <= py_q + 1'b1;
          end else begin
            px_q <= px_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o          = done_q;
  assign kind_o          = res_q.kind;
  assign status_o        = res_q.status;
  assign pix_x_o         = res_q.px;
  assign pix_y_o         = res_q.py;
  assign covered_o       = res_q.cov;
  assign depth_written_o = res_q.wr;
  assign pix_depth_o     = res_q.depth;
  assign bary_u_o        = res_q.u;
  assign bary_v_o        = res_q.v;
  assign last_pixel_o    = res_q.last;

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the edge-function triangle rasterizer. A queue of
// vertex loads and pixel advances feeds a command driver with random gaps;
// an internal predictor of set-up, coverage, depth test and perspective
// weights checks every result beat in order. Registers change between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ter_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SETTLE      = 120;

  typedef struct packed {
    logic        op;
    logic [1:0]  slot;
    logic [15:0] x;
    logic [15:0] y;
    logic [23:0] depth;
    logic [23:0] inv_w;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [7:0]  px;
    logic [7:0]  py;
    logic        cov;
    logic        wr;
    logic [23:0] depth;
    logic [15:0] u;
    logic [15:0] v;
    logic        last;
  } frag_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_WIDTH;
  logic [8:0] cfg_data_i = '0;
  cmd_t cur = '0;
  logic done_o, covered_o, depth_written_o, last_pixel_o;
  logic [1:0] kind_o;
  logic [2:0] status_o;
  logic [7:0] pix_x_o, pix_y_o;
  logic [23:0] pix_depth_o;
  logic [15:0] bary_u_o, bary_v_o;

  triangle_edge_rasterizer uut (
    .clk_i, .rst_ni, .start, .busy,
    .operation_i(cur.op), .vertex_slot_i(cur.slot), .vert_x_i(cur.x), .vert_y_i(cur.y),
    .vert_depth_i(cur.depth), .vert_inv_w_i(cur.inv_w),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_o, .kind_o, .status_o, .pix_x_o, .pix_y_o, .covered_o, .depth_written_o,
    .pix_depth_o, .bary_u_o, .bary_v_o, .last_pixel_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  int unsigned vp_w = 256, vp_h = 256;
  bit ccw = 1'b1, cull = 1'b1;
  longint cx[3], cy[3];
  longint unsigned cz[3], cw[3];
  longint area;
  bit [2:0] ties;
  int unsigned bx0, bx1, by0, by1, scan_x, scan_y;
  bit tri_on;
  logic [23:0] zbuf [0:65535];

  cmd_t  pending[$];
  frag_t frags_due[$];
  int unsigned gap, cycles, errors, n_setup_ok, n_cov, n_zwr;
  bit took, idle_on;

  function automatic int unsigned clamp_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                      longint px, longint py);
    return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
  endfunction

  function automatic bit tie_dir(longint dx, longint dy);
    return (dx != 0) ? (dx > 0) : (dy > 0);
  endfunction

  function automatic logic [15:0] ratio16(longint unsigned n, longint unsigned d);
    longint unsigned r;
    logic [15:0] q;
    r = n;
    q = '0;
    if (d == 0) return '0;
    if (n >= d) return 16'hFFFF;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r -= d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic bit in_edge(longint e, bit tie);
    return (e == 0) ? tie : (e > 0);
  endfunction

  function automatic status_e triangle_setup();
    longint s, a, t, xmin, xmax, ymin, ymax;
    longint unsigned tu;
    s = ccw ? 1 : -1;
    a = s * edge_val(cx[0], cy[0], cx[1], cy[1], cx[2], cy[2]);
    if (a == 0) return STAT_ZERO;
    if (a < 0) begin
      if (cull) return STAT_CULLED;
      t = cx[1]; cx[1] = cx[2]; cx[2] = t;
      t = cy[1]; cy[1] = cy[2]; cy[2] = t;
      tu = cz[1]; cz[1] = cz[2]; cz[2] = tu;
      tu = cw[1]; cw[1] = cw[2]; cw[2] = tu;
      a = -a;
    end
    xmin = cx[0]; xmax = cx[0]; ymin = cy[0]; ymax = cy[0];
    for (int i = 1; i < 3; i++) begin
      if (cx[i] < xmin) xmin = cx[i];
      if (cx[i] > xmax) xmax = cx[i];
      if (cy[i] < ymin) ymin = cy[i];
      if (cy[i] > ymax) ymax = cy[i];
    end
    if (xmin + 16 > longint'(vp_w) * 16 || xmax < 0 ||
        ymin + 16 > longint'(vp_h) * 16 || ymax < 0)
      return STAT_OUTSIDE;
    bx0 = (xmin < 0) ? 0 : int'(xmin >>> 4);
    bx1 = ((xmax >>> 4) > vp_w - 1) ? vp_w - 1 : int'(xmax >>> 4);
    by0 = (ymin < 0) ? 0 : int'(ymin >>> 4);
    by1 = ((ymax >>> 4) > vp_h - 1) ? vp_h - 1 : int'(ymax >>> 4);
    ties[0] = tie_dir(cx[2] - cx[1], cy[2] - cy[1]);
    ties[1] = tie_dir(cx[0] - cx[2], cy[0] - cy[2]);
    ties[2] = tie_dir(cx[1] - cx[0], cy[1] - cy[0]);
    area = a;
    scan_x = bx0;
    scan_y = by0;
    tri_on = 1'b1;
    return STAT_OK;
  endfunction

  function automatic void shade_pixel(inout frag_t f);
    longint sx, sy, s, e0, e1, e2;
    longint unsigned z, n0, n1, n2, idx;
    sx = (2 * scan_x + 1) * 16;
    sy = (2 * scan_y + 1) * 16;
    s = ccw ? 1 : -1;
    e0 = s * edge_val(2*cx[1], 2*cy[1], 2*cx[2], 2*cy[2], sx, sy);
    e1 = s * edge_val(2*cx[2], 2*cy[2], 2*cx[0], 2*cy[0], sx, sy);
    e2 = s * edge_val(2*cx[0], 2*cy[0], 2*cx[1], 2*cy[1], sx, sy);
    f.px = scan_x[7:0];
    f.py = scan_y[7:0];
    f.cov = in_edge(e0, ties[0]) && in_edge(e1, ties[1]) && in_edge(e2, ties[2]);
    if (f.cov) begin
      z = (e0 * cz[0] + e1 * cz[1] + e2 * cz[2]) / (area * 4);
      n0 = e0 * cw[0];
      n1 = e1 * cw[1];
      n2 = e2 * cw[2];
      idx = scan_y * vp_w + scan_x;
      if (idx < 65536 && z[31:0] < {8'h0, zbuf[idx]}) begin
        zbuf[idx] = z[23:0];
        f.wr = 1'b1;
        n_zwr++;
      end
      f.depth = z[23:0];
      f.u = ratio16(n0, n0 + n1 + n2);
      f.v = ratio16(n1, n0 + n1 + n2);
      n_cov++;
    end
    if (scan_x >= bx1) begin
      scan_x = bx0;
      if (scan_y >= by1) begin
        tri_on = 1'b0;
        f.last = 1'b1;
      end else begin
        scan_y++;
      end
    end else begin
      scan_x++;
    end
  endfunction

  function automatic frag_t predict_beat(cmd_t c);
    frag_t f;
    f = '0;
    f.kind = KIND_VERTEX;
    f.status = STAT_OK;
    if (c.op == OP_LOAD) begin
      tri_on = 1'b0;
      if (c.slot == SLOT_INVALID) begin
        f.status = STAT_NO_TRI;
        return f;
      end
      cx[c.slot] = longint'(signed'(c.x));
      cy[c.slot] = longint'(signed'(c.y));
      cz[c.slot] = c.depth;
      cw[c.slot] = c.inv_w;
      if (c.slot != SLOT_SETUP) return f;
      f.kind = KIND_SETUP;
      f.status = triangle_setup();
      if (f.status == STAT_OK) begin
        f.px = bx0[7:0];
        f.py = by0[7:0];
        n_setup_ok++;
      end
      return f;
    end
    f.kind = KIND_PIXEL;
    if (!tri_on) begin
      f.status = STAT_NO_TRI;
      return f;
    end
    shade_pixel(f);
    return f;
  endfunction

  // check result beats, then predict the command accepted at this edge
  always @(posedge clk_i) begin
    frag_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("triangle_edge_rasterizer: mismatch");
      $finish;
    end
    if (rst_ni && done_o) begin
      got = {kind_e'(kind_o), status_e'(status_o), pix_x_o, pix_y_o, covered_o,
             depth_written_o, pix_depth_o, bary_u_o, bary_v_o, last_pixel_o};
      if (frags_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = frags_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("beat mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
    if (rst_ni && start && !busy) frags_due.push_back(predict_beat(cur));
    took <= rst_ni && start && !busy;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !took) begin
        // hold until taken
      end else if (gap != 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending.size() != 0) begin
        cur <= pending.pop_front();
        start <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) gap <= $urandom_range(1, 8);
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic cmd_t vtx(logic [1:0] slot, logic [15:0] x, logic [15:0] y,
                               logic [23:0] z, logic [23:0] w);
    return {OP_LOAD, slot, x, y, z, w};
  endfunction

  function automatic void push_steps(int n);
    repeat (n) pending.push_back({OP_ADVANCE, 2'($urandom_range(0, 3)), 16'($urandom),
                                  16'($urandom), 24'($urandom), 24'($urandom)});
  endfunction

  // small triangle near a random pixel, random order so some are back faces
  function automatic void push_triangle();
    int bxp, byp, span;
    logic [15:0] x, y;
    bxp = $urandom_range(0, 9) == 0 ? -2 : $urandom_range(0, 255);
    byp = $urandom_range(0, 9) == 0 ? -2 : $urandom_range(0, 255);
    if ($urandom_range(0, 3) == 0) begin
      bxp = $urandom_range(0, 6);
      byp = $urandom_range(0, 6);
    end
    span = $urandom_range(1, 6) * 16;
    for (int i = 0; i < 3; i++) begin
      if (i == 2 && $urandom_range(0, 15) == 0) begin
        x = pending[pending.size()-1].x;
        y = pending[pending.size()-1].y;
      end else begin
        x = 16'(bxp * 16 + $urandom_range(0, span));
        y = 16'(byp * 16 + $urandom_range(0, span));
      end
      pending.push_back(vtx(i[1:0], x, y, 24'($urandom),
                            $urandom_range(0, 7) == 0 ? 24'd0 : 24'($urandom)));
    end
    push_steps($urandom_range(0, 5) == 0 ? $urandom_range(1, 6) : $urandom_range(10, 60));
  endfunction

  task automatic drain();
    while (pending.size() != 0 || start || frags_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    case (idx)
      CFG_WIDTH:   vp_w = clamp_dim(val);
      CFG_HEIGHT:  vp_h = clamp_dim(val);
      CFG_WINDING: ccw = val[0];
      default:     cull = val[0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    logic [8:0] widths [8] = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd37, 9'd256, 9'd128, 9'd256};
    logic [8:0] heights[8] = '{9'd256, 9'd256, 9'd1, 9'd300, 9'd19, 9'd2, 9'd256, 9'd256};
    int r;
    for (int i = 0; i < 65536; i++) zbuf[i] = '1;
    idle_on = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (busy) @(negedge clk_i);

    // directed: full load, ccw front face, traversal of 18 of 25 pixels with ties on pixel centres
    pending.push_back(vtx(2'd0, 16'd8, 16'd8, 24'd1000, 24'h010000));
    pending.push_back(vtx(2'd1, 16'd8, 16'd72, 24'd2000, 24'h020000));
    pending.push_back(vtx(2'd2, 16'd72, 16'd8, 24'hFFFFFF, 24'hFFFFFF));
    push_steps(18);
    pending.push_back(vtx(SLOT_INVALID, 16'h7FFF, 16'h8000, 24'hFFFFFF, 24'd0));
    pending.push_back(vtx(2'd2, 16'd8, 16'd8, 24'd0, 24'd0));               // zero area
    pending.push_back(vtx(2'd0, 16'h8000, 16'h8000, 24'd0, 24'd0));
    pending.push_back(vtx(2'd1, 16'h8000, 16'h8010, 24'd0, 24'd0));
    pending.push_back(vtx(2'd2, 16'h8010, 16'h8000, 24'd0, 24'd0));         // outside
    pending.push_back(vtx(2'd0, 16'd0, 16'd0, 24'd5, 24'd0));
    pending.push_back(vtx(2'd1, 16'd40, 16'd0, 24'd5, 24'd0));
    pending.push_back(vtx(2'd2, 16'd0, 16'd40, 24'd5, 24'd0));              // back face, culled
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_WIDTH, widths[ph]);
      write_reg(CFG_HEIGHT, heights[ph]);
      write_reg(CFG_WINDING, 9'($urandom_range(0, 1)));
      write_reg(CFG_CULL, ph == 0 ? 9'd0 : 9'($urandom_range(0, 1)));
      idle_on = (ph < 6) && (ph != 3);
      while (pending.size() < 140) begin
        r = $urandom_range(0, 19);
        if (r == 0) pending.push_back(vtx(2'($urandom_range(0, 3)), 16'($urandom),
                                          16'($urandom), 24'($urandom), 24'($urandom)));
        else if (r == 1) push_steps($urandom_range(1, 3));
        else push_triangle();
      end
      drain();
    end

    $display("ran %0d triangle set-ups inside the viewport, %0d covered pixels, %0d depth writes",
             n_setup_ok, n_cov, n_zwr);
    $display("over eight register settings with winding, culling and viewport extremes");
    if (errors == 0) begin
      $display("triangle_edge_rasterizer: match");
    end else begin
      $display("%0d mismatches", errors);
      $display("triangle_edge_rasterizer: mismatch");
    end
    $finish;
  end

endmodule
